// File: src/sat_pkg.sv
// Shared types and constants for the servo angle table PWM unit.
package sat_pkg;

    localparam logic [7:0]  ANGLE_LIMIT     = 8'd180;
    localparam logic [11:0] PULSE_MIN_RESET = 12'd125;
    localparam logic [11:0] PULSE_MAX_RESET = 12'd460;

    // ceil(2^28 / 180): exact floor quotient for products below 2^20
    localparam logic [20:0] RECIP_K     = 21'd1491309;
    localparam int          RECIP_SHIFT = 28;

    localparam logic REG_PULSE_MIN = 1'b0;
    localparam logic REG_PULSE_MAX = 1'b1;

    typedef enum logic [2:0] {
        ACT_ATTACH  = 3'd0,
        ACT_SET     = 3'd1,
        ACT_MOVE    = 3'd2,
        ACT_REFRESH = 3'd3,
        ACT_HOME    = 3'd4,
        ACT_DETACH  = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        MODE_SINGLE,
        MODE_REFRESH,
        MODE_HOME
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOAD,
        ST_CALC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [7:0]  angle;
        logic [11:0] pulse_min;
        logic [11:0] pulse_max;
    } duty_req_t;

endpackage

// File: src/sat_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// File: src/sat_duty.sv
// Three-stage angle to PWM count mapper: multiply, reciprocal divide by 180, offset.
module sat_duty
    import sat_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  duty_req_t   req,
    output logic        done,
    output logic [11:0] duty
);

    logic               v1_reg, v2_reg, v3_reg;
    logic signed [21:0] p_reg;
    logic [11:0]        lo1_reg, lo2_reg;
    logic               neg_reg;
    logic [11:0]        q_reg;
    logic [11:0]        duty_reg;

    logic signed [12:0] diff;
    logic signed [21:0] p_next;
    logic [21:0]        p_abs;
    logic [40:0]        recip_prod;
    logic [12:0]        q_signed;
    logic [12:0]        sum;

    always_comb begin
        diff       = $signed({1'b0, req.pulse_max}) - $signed({1'b0, req.pulse_min});
        p_next     = $signed({1'b0, req.angle}) * diff;
        p_abs      = p_reg[21] ? 22'(-p_reg) : 22'(p_reg);
        recip_prod = 41'(p_abs[19:0]) * 41'(RECIP_K);
        q_signed   = neg_reg ? 13'(-{1'b0, q_reg}) : {1'b0, q_reg};
        sum        = q_signed + {1'b0, lo2_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            p_reg   <= p_next;
            lo1_reg <= req.pulse_min;
        end
        if (v1_reg) begin
            neg_reg <= p_reg[21];
            q_reg   <= recip_prod[RECIP_SHIFT +: 12];
            lo2_reg <= lo1_reg;
        end
        if (v2_reg) begin
            duty_reg <= sum[11:0];
        end
    end

    assign done = v3_reg;
    assign duty = duty_reg;

endmodule

// File: src/servo_angle_table_pwm_unit.sv
// Servo angle table with APB pulse registers and a scan sequencer around one duty mapper.
// Attach, set and detach-all finish in their accept cycle; ready stays high.
// Move: read, load, 3 mapper stages, then output load, which may stall on m_ready.
// Refresh-all / go-home: the scan walks entries up to the last flagged one; each flagged
// entry then goes through the shared mapper and the angle RAM port, one entry at a time.
// Synchronous active-low reset clears flags, sequencer and output valid; pulse regs to 125/460.
module servo_angle_table_pwm_unit
    import sat_pkg::*;
#(
    parameter int SERVO_COUNT = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [3:0]  s_servo,
    input  logic [7:0]  s_angle,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_channel,
    output logic [11:0] m_duty,
    output logic        m_last
);

    localparam int IW = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;

    state_t                 state_reg, state_next;
    mode_t                  mode_reg, mode_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic                   last_reg, last_next;
    logic [SERVO_COUNT-1:0] attached_reg, attached_next;
    logic [SERVO_COUNT-1:0] pending_reg, pending_next;
    logic [11:0]            pulse_min_reg, pulse_max_reg;
    logic                   m_valid_reg;
    logic [3:0]             m_channel_reg;
    logic [11:0]            m_duty_reg;
    logic                   m_last_reg;

    logic                   s_accept;
    logic                   cfg_write;
    logic [7:0]             angle_clamped;
    logic                   servo_ok;
    logic [IW-1:0]          sidx;
    logic                   at_end;
    logic [SERVO_COUNT-1:0] scan_vec;
    logic [SERVO_COUNT-1:0] upper_mask;
    logic                   hit;
    logic                   more;
    logic                   out_load;

    logic                   angle_we;
    logic [IW-1:0]          angle_waddr;
    logic [7:0]             angle_wdata;
    logic [7:0]             angle_rdata;
    logic                   home_we;
    logic [7:0]             home_rdata;

    logic                   duty_start;
    duty_req_t              duty_req;
    logic                   duty_done;
    logic [11:0]            duty_value;

    assign s_accept      = s_valid && s_ready;
    assign cfg_write     = psel && penable && pwrite && pready;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == REG_PULSE_MAX) ? {20'd0, pulse_max_reg}
                                                       : {20'd0, pulse_min_reg};
    assign angle_clamped = (s_angle > ANGLE_LIMIT) ? ANGLE_LIMIT : s_angle;
    assign servo_ok      = 7'(s_servo) < 7'(SERVO_COUNT);
    assign sidx          = IW'(s_servo);
    assign at_end        = idx_reg == IW'(SERVO_COUNT - 1);
    assign scan_vec      = (mode_reg == MODE_HOME) ? attached_reg : pending_reg;
    assign upper_mask    = ~((SERVO_COUNT'(2) << idx_reg) - SERVO_COUNT'(1));
    assign more          = |(scan_vec & upper_mask);
    assign hit           = (mode_reg == MODE_SINGLE) || scan_vec[idx_reg];
    assign out_load      = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    assign duty_req.angle     = (mode_reg == MODE_HOME) ? home_rdata : angle_rdata;
    assign duty_req.pulse_min = pulse_min_reg;
    assign duty_req.pulse_max = pulse_max_reg;

    sat_ram #(.WIDTH(8), .DEPTH(SERVO_COUNT)) u_angle_ram (
        .aclk  (aclk),
        .we    (angle_we),
        .waddr (angle_waddr),
        .wdata (angle_wdata),
        .raddr (idx_reg),
        .rdata (angle_rdata)
    );

    sat_ram #(.WIDTH(8), .DEPTH(SERVO_COUNT)) u_home_ram (
        .aclk  (aclk),
        .we    (home_we),
        .waddr (sidx),
        .wdata (angle_clamped),
        .raddr (idx_reg),
        .rdata (home_rdata)
    );

    sat_duty u_duty (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (duty_start),
        .req     (duty_req),
        .done    (duty_done),
        .duty    (duty_value)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_action == ACT_REFRESH || s_action == ACT_HOME) begin
                        state_next = ST_SCAN;
                    end else if (s_action == ACT_MOVE && servo_ok && attached_reg[sidx]) begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                priority if (hit) begin
                    state_next = ST_LOAD;
                end else if (at_end) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_LOAD: state_next = ST_CALC;
            ST_CALC: begin
                if (duty_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = last_reg ? ST_IDLE : ST_SCAN;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready       = 1'b0;
        mode_next     = mode_reg;
        idx_next      = idx_reg;
        last_next     = last_reg;
        attached_next = attached_reg;
        pending_next  = pending_reg;
        angle_we      = 1'b0;
        angle_waddr   = sidx;
        angle_wdata   = angle_clamped;
        home_we       = 1'b0;
        duty_start    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_accept) begin
                    unique case (s_action)
                        ACT_ATTACH: begin
                            if (servo_ok) begin
                                attached_next[sidx] = 1'b1;
                                home_we             = 1'b1;
                            end
                        end
                        ACT_SET: begin
                            if (servo_ok && attached_reg[sidx]) begin
                                angle_we           = 1'b1;
                                pending_next[sidx] = 1'b1;
                            end
                        end
                        ACT_MOVE: begin
                            if (servo_ok && attached_reg[sidx]) begin
                                angle_we  = 1'b1;
                                mode_next = MODE_SINGLE;
                                idx_next  = sidx;
                            end
                        end
                        ACT_REFRESH: begin
                            mode_next = MODE_REFRESH;
                            idx_next  = '0;
                        end
                        ACT_HOME: begin
                            mode_next = MODE_HOME;
                            idx_next  = '0;
                        end
                        ACT_DETACH: attached_next = '0;
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                priority if (hit) begin
                    last_next = (mode_reg == MODE_SINGLE) || !more;
                end else if (!at_end) begin
                    idx_next = idx_reg + IW'(1);
                end else begin
                    idx_next = idx_reg;
                end
            end
            ST_LOAD: begin
                duty_start            = 1'b1;
                pending_next[idx_reg] = 1'b0;
                if (mode_reg == MODE_HOME) begin
                    angle_we    = 1'b1;
                    angle_waddr = idx_reg;
                    angle_wdata = home_rdata;
                end
            end
            ST_CALC: ;
            ST_OUT: begin
                if (out_load && !last_reg) begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_SINGLE;
            idx_reg       <= '0;
            last_reg      <= 1'b0;
            attached_reg  <= '0;
            pending_reg   <= '0;
            pulse_min_reg <= PULSE_MIN_RESET;
            pulse_max_reg <= PULSE_MAX_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            idx_reg      <= idx_next;
            last_reg     <= last_next;
            attached_reg <= attached_next;
            pending_reg  <= pending_next;
            if (cfg_write) begin
                if (paddr[2] == REG_PULSE_MAX) begin
                    pulse_max_reg <= pwdata[11:0];
                end else begin
                    pulse_min_reg <= pwdata[11:0];
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_channel_reg <= 4'(idx_reg);
            m_duty_reg    <= duty_value;
            m_last_reg    <= last_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_channel = m_channel_reg;
    assign m_duty    = m_duty_reg;
    assign m_last    = m_last_reg;

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> idx_reg <= IW'(SERVO_COUNT - 1))
        else $error("scan index beyond table");

    a_beat_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("output beat loaded outside output state");

    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && last_reg) |=> state_reg == ST_IDLE)
        else $error("sequencer did not finish after last beat");

    a_load_starts_map: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LOAD |=> (state_reg == ST_CALC && !duty_done))
        else $error("mapper start out of step with sequencer");

endmodule
